// ----- design/fcm_pkg.sv -----
// Shared types and constants of the corner marker.
`timescale 1ns / 1ps
`default_nettype none
package fcm_pkg;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_WIDTH     = 2'd0;
  localparam logic [1:0] REG_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  // Item kinds
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  localparam logic [10:0] WIDTH_RESET     = 11'd640;
  localparam logic [10:0] HEIGHT_RESET    = 11'd480;
  localparam logic [7:0]  THRESHOLD_RESET = 8'd10;
  localparam int          SIZE_MIN        = 8;

  // Fixed-point luma weights, scaled by 2^16
  localparam logic [23:0] GRAY_KR = 24'd19661;
  localparam logic [23:0] GRAY_KG = 24'd38666;
  localparam logic [23:0] GRAY_KB = 24'd7209;

  localparam logic [7:0] WHITE = 8'd255;

  // Radius-3 circle in 7x7 window coordinates, center at (3,3), entry 0 is the left pixel
  localparam logic [2:0] CIRCLE_ROW [16] = '{3'd3, 3'd4, 3'd5, 3'd6, 3'd6, 3'd6, 3'd5, 3'd4,
                                             3'd3, 3'd2, 3'd1, 3'd0, 3'd0, 3'd0, 3'd1, 3'd2};
  localparam logic [2:0] CIRCLE_COL [16] = '{3'd0, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6,
                                             3'd6, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};

  typedef struct packed {
    logic bright;
    logic dark;
  } corner_flags_t;

endpackage
`default_nettype wire

// ----- design/fcm_if.sv -----
// Pixel and result channel interfaces of the corner marker.
`timescale 1ns / 1ps
`default_nettype none
interface fcm_pix_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  modport source (output valid, func, red_in, green_in, blue_in, input ready);
  modport sink (input valid, func, red_in, green_in, blue_in, output ready);
endinterface

interface fcm_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       is_corner;
  logic [9:0] out_row;
  logic [9:0] out_col;
  logic       frame_last;
  modport source (output valid, red_out, green_out, blue_out, is_corner, out_row, out_col,
                  frame_last, input ready);
  modport sink (input valid, red_out, green_out, blue_out, is_corner, out_row, out_col,
                frame_last, output ready);
endinterface
`default_nettype wire

// ----- design/fast_corner_marker.sv -----
// Top level of the streaming 16-point corner marker.
//
//  channel   dir  beat contents
//  pixel     in   func, red_in, green_in, blue_in
//  result    out  red_out, green_out, blue_out, is_corner, out_row, out_col, frame_last
//  cfg_*     in   register write: cfg_we, cfg_index, cfg_data
//
// One beat per clock while pixel is ready. A beat that emits reaches the result register
// through the read stage: the line store read happens at the accepting edge, the window
// shift and circle test when the read stage moves into the result register.
// The output register parts the two sides; pixel stalls only when both the read stage
// and the result register are full. Reset and any size write restart the stream.
`timescale 1ns / 1ps
`default_nettype none
module fast_corner_marker #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [10:0] cfg_data,
  fcm_pix_if.sink          pixel,
  fcm_res_if.source        result
);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int LW = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int PW = $clog2(3 * MAX_WIDTH + 5);

  logic [10:0] width_reg;
  logic [10:0] height_reg;
  logic [7:0]  thr_reg;
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [PW-1:0] pend_limit;

  always_comb begin
    if (int'(width_reg) < fcm_pkg::SIZE_MIN) begin
      eff_w = WW'(fcm_pkg::SIZE_MIN);
    end else if (int'(width_reg) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_reg);
    end
    if (int'(height_reg) < fcm_pkg::SIZE_MIN) begin
      eff_h = HW'(fcm_pkg::SIZE_MIN);
    end else if (int'(height_reg) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(height_reg);
    end
    pend_limit = PW'(eff_w) + PW'(eff_w) + PW'(eff_w) + PW'(3);
  end

  // Stream counters
  logic [CW-1:0] in_col, out_col, f_col;
  logic [RW-1:0] in_row, out_row;
  logic [2:0]    in_slot, out_slot, f_slot;
  logic [LW-1:0] in_lin, out_lin;
  logic [PW-1:0] pending;
  logic [CW-1:0] in_col_next, out_col_next, f_col_next;
  logic [RW-1:0] in_row_next, out_row_next;
  logic [2:0]    in_slot_next, out_slot_next, f_slot_next;
  logic [LW-1:0] in_lin_next, out_lin_next;
  logic [PW-1:0] pending_next;

  // Read stage and result register
  logic          s2_valid;
  logic          s2_inner;
  logic          s2_last;
  logic [RW-1:0] s2_row;
  logic [CW-1:0] s2_col;
  logic [2:0]    s2_fslot;
  logic          s2_byp;
  logic [2:0]    s2_wslot;
  logic [7:0]    s2_wgray;
  logic          res_valid;

  logic accept, is_pix, emit, out_free, s2_move;
  logic [23:0] gray_sum;
  logic [7:0]  gray;
  logic inner, last;

  assign out_free    = !res_valid || result.ready;
  assign s2_move     = s2_valid && out_free;
  assign pixel.ready = !s2_valid || out_free;
  assign accept      = pixel.valid && pixel.ready;
  assign is_pix      = pixel.func == fcm_pkg::FUNC_PIXEL;

  assign gray_sum = fcm_pkg::GRAY_KR * 24'(pixel.red_in) + fcm_pkg::GRAY_KG * 24'(pixel.green_in)
                  + fcm_pkg::GRAY_KB * 24'(pixel.blue_in);
  assign gray = gray_sum[23:16];

  always_comb begin
    if (is_pix) begin
      emit = accept && pending >= pend_limit;
    end else begin
      emit = accept && pending != '0 && out_lin >= in_lin;
    end
    inner = int'(out_row) >= 4 && int'(out_row) + 4 <= int'(eff_h)
         && int'(out_col) >= 4 && int'(out_col) + 4 < int'(eff_w);
    last  = int'(out_row) == int'(eff_h) - 1 && int'(out_col) == int'(eff_w) - 1;

    in_col_next  = in_col;
    in_row_next  = in_row;
    in_slot_next = in_slot;
    in_lin_next  = in_lin;
    if (accept && is_pix) begin
      in_col_next = in_col + CW'(1);
      in_lin_next = in_lin + LW'(1);
      if (int'(in_col) + 1 >= int'(eff_w)) begin
        in_col_next  = '0;
        in_slot_next = in_slot + 3'd1;
        in_row_next  = in_row + RW'(1);
        if (int'(in_row) + 1 >= int'(eff_h)) begin
          in_row_next = '0;
          in_lin_next = '0;
        end
      end
    end

    out_col_next  = out_col;
    out_row_next  = out_row;
    out_slot_next = out_slot;
    out_lin_next  = out_lin;
    f_col_next    = f_col;
    f_slot_next   = f_slot;
    if (emit) begin
      out_col_next = out_col + CW'(1);
      out_lin_next = out_lin + LW'(1);
      if (int'(out_col) + 1 >= int'(eff_w)) begin
        out_col_next  = '0;
        out_slot_next = out_slot + 3'd1;
        out_row_next  = out_row + RW'(1);
        if (int'(out_row) + 1 >= int'(eff_h)) begin
          out_row_next = '0;
          out_lin_next = '0;
        end
      end
      // Fetch column runs three pixels ahead of the output position
      f_col_next = f_col + CW'(1);
      if (int'(f_col) + 1 >= int'(eff_w)) begin
        f_col_next  = '0;
        f_slot_next = f_slot + 3'd1;
      end
    end

    pending_next = pending;
    if (accept && is_pix && !emit) begin
      pending_next = pending + PW'(1);
    end else if (accept && !is_pix && emit) begin
      pending_next = pending - PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= fcm_pkg::WIDTH_RESET;
      height_reg <= fcm_pkg::HEIGHT_RESET;
      thr_reg    <= fcm_pkg::THRESHOLD_RESET;
      in_col <= '0; in_row <= '0; in_slot <= '0; in_lin <= '0;
      out_col <= '0; out_row <= '0; out_slot <= '0; out_lin <= '0;
      f_col <= CW'(3); f_slot <= '0;
      pending <= '0;
    end else if (cfg_we && (cfg_index == fcm_pkg::REG_WIDTH || cfg_index == fcm_pkg::REG_HEIGHT)) begin
      if (cfg_index == fcm_pkg::REG_WIDTH) begin
        width_reg <= cfg_data;
      end else begin
        height_reg <= cfg_data;
      end
      in_col <= '0; in_row <= '0; in_slot <= '0; in_lin <= '0;
      out_col <= '0; out_row <= '0; out_slot <= '0; out_lin <= '0;
      f_col <= CW'(3); f_slot <= '0;
      pending <= '0;
    end else begin
      if (cfg_we && cfg_index == fcm_pkg::REG_THRESHOLD) begin
        thr_reg <= cfg_data[7:0];
      end
      in_col <= in_col_next; in_row <= in_row_next; in_slot <= in_slot_next;
      in_lin <= in_lin_next;
      out_col <= out_col_next; out_row <= out_row_next; out_slot <= out_slot_next;
      out_lin <= out_lin_next;
      f_col <= f_col_next; f_slot <= f_slot_next;
      pending <= pending_next;
    end
  end

  logic [7:0][7:0] gray_q;
  logic [23:0]     rgb_q;

  fcm_line_store #(.MAX_WIDTH(MAX_WIDTH)) u_store (
    .clk      (clk),
    .we       (accept && is_pix),
    .wr_slot  (in_slot),
    .wr_col   (in_col),
    .wr_gray  (gray),
    .wr_rgb   ({pixel.red_in, pixel.green_in, pixel.blue_in}),
    .rd_en    (emit),
    .gray_col (f_col),
    .rgb_slot (out_slot),
    .rgb_col  (out_col),
    .gray_q   (gray_q),
    .rgb_q    (rgb_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (accept) begin
      s2_valid <= emit;
    end else if (s2_move) begin
      s2_valid <= 1'b0;
    end
    if (emit) begin
      s2_inner <= inner;
      s2_last  <= last;
      s2_row   <= out_row;
      s2_col   <= out_col;
      s2_fslot <= f_slot;
      // The newest pixel may land in the column being read in the same beat
      s2_byp   <= is_pix && in_col == f_col;
      s2_wslot <= in_slot;
      s2_wgray <= gray;
    end
  end

  logic [6:0][7:0]      new_col;
  logic [6:0][6:0][7:0] win, win_next;
  fcm_pkg::corner_flags_t flags;

  always_comb begin
    logic [2:0] slot;
    for (int i = 0; i < 7; i++) begin
      slot = s2_fslot + 3'(5 + i);
      new_col[i] = gray_q[slot];
      if (s2_byp && slot == s2_wslot) begin
        new_col[i] = s2_wgray;
      end
    end
    for (int r = 0; r < 7; r++) begin
      for (int c = 0; c < 6; c++) begin
        win_next[r][c] = win[r][c + 1];
      end
      win_next[r][6] = new_col[r];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (s2_move) begin
      win <= win_next;
    end
  end

  fcm_corner_test u_test (
    .win   (win_next),
    .thr   (thr_reg),
    .flags (flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s2_move) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
    if (s2_move) begin
      result.is_corner <= s2_inner && (flags.bright || flags.dark);
      if (!s2_inner) begin
        result.red_out   <= '0;
        result.green_out <= '0;
        result.blue_out  <= '0;
      end else if (flags.bright || flags.dark) begin
        result.red_out   <= fcm_pkg::WHITE;
        result.green_out <= fcm_pkg::WHITE;
        result.blue_out  <= fcm_pkg::WHITE;
      end else begin
        result.red_out   <= rgb_q[23:16];
        result.green_out <= rgb_q[15:8];
        result.blue_out  <= rgb_q[7:0];
      end
      result.out_row    <= 10'(s2_row);
      result.out_col    <= 10'(s2_col);
      result.frame_last <= s2_last;
    end
  end

  assign result.valid = res_valid;

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= pend_limit)
    else $error("pending count above window lag");

  a_flush_empty: assert property (@(posedge clk) disable iff (rst)
    accept && !is_pix && pending == '0 |=> !s2_valid)
    else $error("flush emitted with nothing pending");

  a_fetch_lead: assert property (@(posedge clk) disable iff (rst)
    int'(out_col) + 3 == int'(f_col) || int'(out_col) + 3 == int'(f_col) + int'(eff_w))
    else $error("fetch column not three ahead of output");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !out_free |=> s2_valid && $stable(s2_col) && $stable(win))
    else $error("read stage lost while result stalled");
endmodule
`default_nettype wire

// ----- design/fcm_line_store.sv -----
// Eight-row gray and color line stores with registered reads.
`timescale 1ns / 1ps
`default_nettype none
module fcm_line_store #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [2:0]                   wr_slot,
  input  wire logic [$clog2(MAX_WIDTH)-1:0] wr_col,
  input  wire logic [7:0]                   wr_gray,
  input  wire logic [23:0]                  wr_rgb,
  input  wire logic                         rd_en,
  input  wire logic [$clog2(MAX_WIDTH)-1:0] gray_col,
  input  wire logic [2:0]                   rgb_slot,
  input  wire logic [$clog2(MAX_WIDTH)-1:0] rgb_col,
  output logic      [7:0][7:0]              gray_q,
  output logic      [23:0]                  rgb_q
);
  localparam int CW = $clog2(MAX_WIDTH);

  // One gray bank per ring slot so a whole column is read at once
  for (genvar b = 0; b < 8; b++) begin : g_bank
    logic [7:0] bank [MAX_WIDTH];
    always_ff @(posedge clk) begin
      if (we && wr_slot == 3'(b)) begin
        bank[wr_col] <= wr_gray;
      end
      if (rd_en) begin
        gray_q[b] <= bank[gray_col];
      end
    end
  end

  logic [23:0] cmem [8 * (1 << CW)];

  always_ff @(posedge clk) begin
    if (we) begin
      cmem[{wr_slot, wr_col}] <= wr_rgb;
    end
    if (rd_en) begin
      rgb_q <= cmem[{rgb_slot, rgb_col}];
    end
  end
endmodule
`default_nettype wire

// ----- design/fcm_corner_test.sv -----
// Sixteen-point circle test on a 7x7 gray window.
`timescale 1ns / 1ps
`default_nettype none
module fcm_corner_test (
  input  wire logic [6:0][6:0][7:0]    win,
  input  wire logic [7:0]              thr,
  output fcm_pkg::corner_flags_t       flags
);
  always_comb begin
    logic [8:0] ctr;
    logic [8:0] ctr_t;
    logic [8:0] pix;
    logic [8:0] left;
    logic       bright;
    logic       dark;
    ctr    = {1'b0, win[3][3]};
    ctr_t  = ctr + {1'b0, thr};
    left   = {1'b0, win[fcm_pkg::CIRCLE_ROW[0]][fcm_pkg::CIRCLE_COL[0]]};
    bright = ctr > left + {1'b0, thr};
    dark   = ctr_t < left;
    for (int k = 1; k < 16; k++) begin
      pix = {1'b0, win[fcm_pkg::CIRCLE_ROW[k]][fcm_pkg::CIRCLE_COL[k]]};
      if (ctr < pix + {1'b0, thr}) begin
        bright = 1'b0;
      end
      if (ctr_t > pix) begin
        dark = 1'b0;
      end
    end
    flags.bright = bright;
    flags.dark   = dark;
  end
endmodule
`default_nettype wire
